@@ rtl/daq_trigger_word_decoder_top_defines.svh @@
// Assertion helpers for the trigger word decoder.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef DAQ_TRIGGER_WORD_DECODER_TOP_DEFINES_SVH
`define DAQ_TRIGGER_WORD_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define DTWD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define DTWD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/dtwd_pkg.sv @@
`default_nettype none

package dtwd_pkg;

	// Readout word type codes (bits 30:27 of a type-defining word)
	localparam logic [3:0] TYPE_HEADER   = 4'd0;
	localparam logic [3:0] TYPE_TRAILER  = 4'd1;
	localparam logic [3:0] TYPE_EVENT    = 4'd2;
	localparam logic [3:0] TYPE_TIME     = 4'd3;
	localparam logic [3:0] TYPE_CLUSTER  = 4'd12;
	localparam logic [3:0] TYPE_DECISION = 4'd13;
	localparam logic [3:0] TYPE_FILLER   = 4'd15;

	// Result kinds
	localparam logic [3:0] KIND_HDR_OK     = 4'd0;
	localparam logic [3:0] KIND_HDR_BAD    = 4'd1;
	localparam logic [3:0] KIND_HDR_CONT   = 4'd2;
	localparam logic [3:0] KIND_TRAILER    = 4'd3;
	localparam logic [3:0] KIND_EVENT      = 4'd4;
	localparam logic [3:0] KIND_TIME       = 4'd5;
	localparam logic [3:0] KIND_CLUS_ENRG  = 4'd6;
	localparam logic [3:0] KIND_CLUS_POS   = 4'd7;
	localparam logic [3:0] KIND_TRIG       = 4'd8;
	localparam logic [3:0] KIND_TRIG_CONT  = 4'd9;
	localparam logic [3:0] KIND_IGNORED    = 4'd10;
	localparam logic [3:0] KIND_REJECTED   = 4'd11;

	// Configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int SLOT_W     = 5;
	localparam logic REG_SLOT_NUMBER = 1'b0;

	// Input transaction
	typedef struct packed {
		logic [31:0] data_word;
		logic        restart;
	} dtwd_in_t;

	// Result transaction
	typedef struct packed {
		logic [3:0]  kind;
		logic [4:0]  slot_field;
		logic [19:0] value_a;
		logic [7:0]  value_b;
		logic [47:0] trigger_time;
		logic [6:0]  hit_time;
		logic [3:0]  cluster_blocks;
		logic [4:0]  cluster_x;
		logic [5:0]  cluster_y;
		logic [2:0]  trigger_types;
		logic        trailer_seen;
	} dtwd_out_t;

	// Sticky decoder state
	typedef struct packed {
		logic [3:0]  cur_type;
		logic        slot_ok;
		logic        trailer_flag;
		logic [23:0] time_lo;
		logic [23:0] time_hi;
	} dtwd_state_t;

	localparam dtwd_state_t STATE_RESET = '{
		cur_type:     TYPE_FILLER,
		slot_ok:      1'b0,
		trailer_flag: 1'b0,
		time_lo:      24'd0,
		time_hi:      24'd0
	};

endpackage

`default_nettype wire

@@ rtl/dtwd_cfg.sv @@
`default_nettype none

module dtwd_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [dtwd_pkg::CFG_ADDR_W-1:0]   paddr,
	input  wire logic [dtwd_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic      [dtwd_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                                   pready,
	output logic      [dtwd_pkg::SLOT_W-1:0]       slot_number
);

	logic [dtwd_pkg::SLOT_W-1:0] slot_number_q;
	logic                        wr_en;
	logic                        hit_slot;

	assign pready   = 1'b1;
	assign hit_slot = (paddr[dtwd_pkg::CFG_ADDR_W-1] == dtwd_pkg::REG_SLOT_NUMBER);
	assign wr_en    = psel && penable && pwrite && pready;

	// Slot register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_number_q <= '0;
		end else if (wr_en && hit_slot) begin
			slot_number_q <= pwdata[dtwd_pkg::SLOT_W-1:0];
		end
	end

	// Read back; unmapped addresses read zero
	always_comb begin
		prdata = '0;
		if (hit_slot) begin
			prdata = {{(dtwd_pkg::CFG_DATA_W-dtwd_pkg::SLOT_W){1'b0}}, slot_number_q};
		end
	end

	assign slot_number = slot_number_q;

endmodule

`default_nettype wire

@@ rtl/dtwd_decode.sv @@
`default_nettype none

module dtwd_decode (
	input  wire dtwd_pkg::dtwd_state_t         state,
	input  wire dtwd_pkg::dtwd_in_t            word,
	input  wire logic [dtwd_pkg::SLOT_W-1:0]   slot_number,
	output dtwd_pkg::dtwd_state_t              state_nxt,
	output dtwd_pkg::dtwd_out_t                res
);

	logic                        defining;
	logic [dtwd_pkg::SLOT_W-1:0] slot;
	logic [31:0]                 w;
	dtwd_pkg::dtwd_state_t       st;

	assign w        = word.data_word;
	assign defining = w[31];
	assign slot     = w[26:22];

	// Single-word decode against the sticky state
	always_comb begin
		st  = word.restart ? dtwd_pkg::STATE_RESET : state;
		res = '0;
		if (defining) begin
			st.cur_type = w[30:27];
		end

		if (!st.slot_ok && (st.cur_type != dtwd_pkg::TYPE_HEADER)) begin
			res.kind = dtwd_pkg::KIND_REJECTED;
		end else begin
			unique case (st.cur_type)
				dtwd_pkg::TYPE_HEADER: begin
					if (defining) begin
						res.slot_field = slot;
						st.slot_ok     = (slot == slot_number);
						if (slot == slot_number) begin
							res.kind    = dtwd_pkg::KIND_HDR_OK;
							res.value_a = {10'd0, w[17:8]};
							res.value_b = w[7:0];
						end else begin
							res.kind = dtwd_pkg::KIND_HDR_BAD;
						end
					end else begin
						res.kind = dtwd_pkg::KIND_HDR_CONT;
					end
				end
				dtwd_pkg::TYPE_TRAILER: begin
					st.trailer_flag = 1'b1;
					res.kind        = dtwd_pkg::KIND_TRAILER;
					res.slot_field  = slot;
					res.value_a     = w[19:0];
				end
				dtwd_pkg::TYPE_EVENT: begin
					res.kind    = dtwd_pkg::KIND_EVENT;
					res.value_a = w[19:0];
				end
				dtwd_pkg::TYPE_TIME: begin
					// defining word carries the low half, continuation the high half
					if (defining) begin
						st.time_lo = w[23:0];
					end else begin
						st.time_hi = w[23:0];
					end
					res.kind         = dtwd_pkg::KIND_TIME;
					res.trigger_time = {st.time_hi, st.time_lo};
				end
				dtwd_pkg::TYPE_CLUSTER: begin
					if (defining) begin
						res.kind    = dtwd_pkg::KIND_CLUS_ENRG;
						res.value_a = {6'd0, w[13:0]};
					end else begin
						res.kind           = dtwd_pkg::KIND_CLUS_POS;
						res.hit_time       = w[6:0];
						res.cluster_blocks = w[14:11];
						res.cluster_x      = w[19:15];
						res.cluster_y      = w[25:20];
					end
				end
				dtwd_pkg::TYPE_DECISION: begin
					if (defining) begin
						res.kind          = dtwd_pkg::KIND_TRIG;
						res.value_a       = {4'd0, w[15:0]};
						res.hit_time      = w[22:16];
						res.trigger_types = w[2:0];
					end else begin
						res.kind = dtwd_pkg::KIND_TRIG_CONT;
					end
				end
				default: begin
					res.kind = dtwd_pkg::KIND_IGNORED;
				end
			endcase
		end

		res.trailer_seen = st.trailer_flag;
		state_nxt        = st;
	end

endmodule

`default_nettype wire

@@ rtl/daq_trigger_word_decoder_top.sv @@
// Readout trigger word decoder.
// Input channel (word_valid/word_ready/word): one 32-bit readout word plus a
// restart flag per transaction. Output channel (result_valid/result_ready/
// result): exactly one decoded result per input word, in order.
// Configuration: APB-style port, register 0 at byte address 0 holds the
// expected backplane slot (5 bits); pready is tied high.
// Pipeline: a word accepted is held in the input register, decoded from it,
// and its result is registered in the result register, from which it is
// offered on the output channel.
// Throughput: one word per cycle while the output is not stalled. The sticky
// type, slot match, trailer flag and time halves update as a word leaves the
// input register, so the next word decodes against the updated values.
// Stall: while result_ready is low and a result is waiting, a word in the
// input register holds there and word_ready drops; an empty input register
// still takes one more word first. Nothing is lost or repeated.
// Reset: arst_n clears both stage valids, the sticky state (type = filler,
// no slot match, no trailer, time halves zero) and the slot register.
`default_nettype none

`include "daq_trigger_word_decoder_top_defines.svh"

module daq_trigger_word_decoder_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               word_valid,
	output logic                                    word_ready,
	input  wire dtwd_pkg::dtwd_in_t                 word,
	output logic                                    result_valid,
	input  wire logic                               result_ready,
	output dtwd_pkg::dtwd_out_t                     result,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [dtwd_pkg::CFG_ADDR_W-1:0]    paddr,
	input  wire logic [dtwd_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic      [dtwd_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                    pready
);

	logic                        valid_s1;
	dtwd_pkg::dtwd_in_t          word_s1;
	logic                        valid_s2;
	dtwd_pkg::dtwd_out_t         result_s2;
	dtwd_pkg::dtwd_state_t       state_q;
	dtwd_pkg::dtwd_state_t       state_nxt;
	dtwd_pkg::dtwd_out_t         res;
	logic [dtwd_pkg::SLOT_W-1:0] slot_number;
	logic                        advance_s1;

	dtwd_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.slot_number (slot_number)
	);

	dtwd_decode u_decode (
		.state       (state_q),
		.word        (word_s1),
		.slot_number (slot_number),
		.state_nxt   (state_nxt),
		.res         (res)
	);

	// Handshake: stage 1 moves on when the result register is free or drains
	assign advance_s1 = valid_s1 && (!valid_s2 || result_ready);
	assign word_ready = !valid_s1 || advance_s1;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= dtwd_pkg::STATE_RESET;
		end else begin
			if (word_ready) begin
				valid_s1 <= word_valid;
			end
			if (advance_s1) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (word_valid && word_ready) begin
			word_s1 <= word;
		end
		if (advance_s1) begin
			result_s2 <= res;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// Checks
	`DTWD_ASSERT_NOW(a_stall_cause, !word_ready, valid_s1 && valid_s2 && !result_ready, "input stalled without a blocked result")
	`DTWD_ASSERT_NOW(a_hdr_ok_slot, result_valid && (result.kind == dtwd_pkg::KIND_HDR_OK), result.slot_field == slot_number, "header ok with mismatched slot")
	`DTWD_ASSERT_NEXT(a_hdr_ok_state, advance_s1 && (res.kind == dtwd_pkg::KIND_HDR_OK), state_q.slot_ok, "slot match not recorded after good header")
	`DTWD_ASSERT_NOW(a_kind_range, result_valid, result.kind <= dtwd_pkg::KIND_REJECTED, "result kind out of range")

endmodule

`default_nettype wire
